>>> rtl/afc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_pkg
// Shared types and pipeline constants of the box culling pipeline.
// ============================================================================
package afc_pkg;

    localparam int WORD_W   = 32;          // field width of coordinates and matrix
    localparam int ACC_W    = 64;          // exact products and dot products
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CORN = 8;
    localparam int QBITS    = 32;          // quotient bits produced by the divider

    // stage map: two transform stages, divider (prep, QBITS steps, finish),
    // reduction, output register
    localparam int XF_STAGES  = 2;
    localparam int DIV_STAGES = QBITS + 2;
    localparam int RED_STAGES = 2;
    localparam int NST        = XF_STAGES + DIV_STAGES + RED_STAGES;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef t_word t_mat [4][4];
    typedef t_word t_vec3 [3];
    typedef t_acc  t_row4 [4];
    typedef t_row4 t_corn_num [NUM_CORN];
    typedef t_vec3 t_corn_val [NUM_CORN];

endpackage

>>> rtl/aabb_frustum_cull.sv
`timescale 1ns / 1ps
// ============================================================================
// aabb_frustum_cull
// View-volume culling of axis-aligned boxes through a programmable 4x4 matrix.
//
//  channel   direction  tdata (low bit first)                     tuser
//  s_axis    in         box_min_x/y/z, box_max_x/y/z (6 x 32)      -
//  m_axis    out        view_min_x/y/z, view_max_x/y/z (6 x 32)    inside_view, degenerate
//  cfg       in         write enable, index, 64-bit data           -
//
// One box is accepted per cycle while the output is not stalled; the divider has 32 steps.
// Each stage moves on when it is empty or the stage after it moves, so bubbles
// are squeezed out and a stalled output holds its item without loss.
// Reset clears the valid bits and loads the identity matrix.
// ============================================================================
module aabb_frustum_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [191:0]                     i_s_axis_tdata,  // box_min_x..z, box_max_x..z
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [191:0]                     o_m_axis_tdata,  // view_min_x..z, view_max_x..z
    output logic [1:0]                       o_m_axis_tuser,  // inside_view, degenerate
    input  logic                             i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                      i_cfg_data
);
    import afc_pkg::*;

    localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
    localparam logic [63:0] ONE_HI = 64'(1) << (FRAC_BITS + 32);

    logic [63:0] r_mvp [NUM_REGS];
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    t_mat      mat;
    t_vec3     box_min;
    t_vec3     box_max;
    t_corn_num num;
    t_corn_val val;
    logic [NUM_CORN-1:0] zero;
    logic      in_view;
    logic      degen;
    t_vec3     vmin;
    t_vec3     vmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_mvp[i] <= '0;
            end
            r_mvp[0] <= ONE_LO;
            r_mvp[2] <= ONE_HI;
            r_mvp[5] <= ONE_LO;
            r_mvp[7] <= ONE_HI;
        end else if (i_cfg_we) begin
            r_mvp[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                mat[r][c] = (c % 2 == 1) ? t_word'(r_mvp[r*2 + c/2][63:32])
                                         : t_word'(r_mvp[r*2 + c/2][31:0]);
            end
        end
        for (int a = 0; a < 3; a++) begin
            box_min[a] = t_word'(i_s_axis_tdata[a*32 +: 32]);
            box_max[a] = t_word'(i_s_axis_tdata[(a+3)*32 +: 32]);
        end
    end

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int k = NST-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    afc_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .i_clk     (i_clk),
        .i_en      (en[XF_STAGES-1:0]),
        .i_box_min (box_min),
        .i_box_max (box_max),
        .i_mat     (mat),
        .o_num     (num)
    );

    for (genvar k = 0; k < NUM_CORN; k++) begin : g_div
        afc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_en   (en[XF_STAGES +: DIV_STAGES]),
            .i_num  (num[k]),
            .o_val  (val[k]),
            .o_zero (zero[k])
        );
    end

    afc_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
        .i_clk    (i_clk),
        .i_en     (en[NST-1 -: RED_STAGES]),
        .i_val    (val),
        .i_zero   (zero),
        .o_inside (in_view),
        .o_degen  (degen),
        .o_vmin   (vmin),
        .o_vmax   (vmax)
    );

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tuser  = {degen, in_view};
    assign o_m_axis_tdata  = {vmax[2], vmax[1], vmax[0], vmin[2], vmin[1], vmin[0]};

endmodule

>>> rtl/afc_xform.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_xform
// Builds the eight box corners and multiplies each by the 4x4 matrix:
// one stage of exact products, one stage of floored sums.
// ============================================================================
module afc_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic [1:0]        i_en,
    input  afc_pkg::t_vec3    i_box_min,
    input  afc_pkg::t_vec3    i_box_max,
    input  afc_pkg::t_mat     i_mat,
    output afc_pkg::t_corn_num o_num
);
    import afc_pkg::*;

    t_acc r_prod [NUM_CORN][4][3];
    t_acc r_num  [NUM_CORN][4];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < NUM_CORN; k++) begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[k][r][c] <= t_acc'(i_mat[r][c]) *
                            t_acc'(((k >> c) & 1) != 0 ? i_box_max[c] : i_box_min[c]);
                    end
                end
            end
        end
    end

    // The arithmetic shift floors each product; column 3 multiplies 1.0.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < NUM_CORN; k++) begin
                for (int r = 0; r < 4; r++) begin
                    r_num[k][r] <= t_acc'(i_mat[r][3]) +
                                   (r_prod[k][r][0] >>> FRAC_BITS) +
                                   (r_prod[k][r][1] >>> FRAC_BITS) +
                                   (r_prod[k][r][2] >>> FRAC_BITS);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CORN; k++) begin
            for (int r = 0; r < 4; r++) begin
                o_num[k][r] = r_num[k][r];
            end
        end
    end

endmodule

>>> rtl/afc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_div
// Pipelined restoring divider for one corner: x, y and z over a shared w,
// one quotient bit per stage, truncated toward zero and saturated.
// ============================================================================
module afc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic [afc_pkg::DIV_STAGES-1:0]  i_en,
    input  afc_pkg::t_row4                  i_num,
    output afc_pkg::t_vec3                  o_val,
    output logic                            o_zero
);
    import afc_pkg::*;

    logic [ACC_W-1:0]  r_d    [QBITS+1];
    logic              r_zero [QBITS+1];
    logic [ACC_W-1:0]  r_rem  [QBITS+1][3];
    logic [QBITS-1:0]  r_q    [QBITS+1][3];
    logic [QBITS-1:0]  r_low  [QBITS+1][3];
    logic              r_neg  [QBITS+1][3];
    logic              r_ovf  [QBITS+1][3];
    t_word             r_val  [3];
    logic              r_zout;

    // Prep: magnitudes, the integer part above the fraction window seeds the
    // remainder; if it already reaches the divisor the quotient overflows.
    always_ff @(posedge i_clk) begin
        logic [ACC_W-1:0] mag_d;
        logic [ACC_W-1:0] mag_n;
        logic [ACC_W-1:0] hi;
        if (i_en[0]) begin
            mag_d = i_num[3][ACC_W-1] ? ACC_W'(-i_num[3]) : ACC_W'(i_num[3]);
            r_d[0]    <= mag_d;
            r_zero[0] <= (i_num[3] == '0);
            for (int a = 0; a < 3; a++) begin
                mag_n = i_num[a][ACC_W-1] ? ACC_W'(-i_num[a]) : ACC_W'(i_num[a]);
                hi    = mag_n >> (QBITS - FRAC_BITS);
                r_rem[0][a] <= hi;
                r_ovf[0][a] <= (hi >= mag_d);
                r_low[0][a] <= QBITS'(mag_n << FRAC_BITS);
                r_neg[0][a] <= i_num[a][ACC_W-1] ^ i_num[3][ACC_W-1];
                r_q[0][a]   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [ACC_W:0] r2;
        for (int s = 0; s < QBITS; s++) begin
            if (i_en[s+1]) begin
                r_d[s+1]    <= r_d[s];
                r_zero[s+1] <= r_zero[s];
                for (int a = 0; a < 3; a++) begin
                    r2 = {r_rem[s][a], r_low[s][a][QBITS-1-s]};
                    if (r2 >= {1'b0, r_d[s]}) begin
                        r_rem[s+1][a] <= ACC_W'(r2 - {1'b0, r_d[s]});
                        r_q[s+1][a]   <= r_q[s][a] | (QBITS'(1) << (QBITS-1-s));
                    end else begin
                        r_rem[s+1][a] <= ACC_W'(r2);
                        r_q[s+1][a]   <= r_q[s][a];
                    end
                    r_low[s+1][a] <= r_low[s][a];
                    r_neg[s+1][a] <= r_neg[s][a];
                    r_ovf[s+1][a] <= r_ovf[s][a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES-1]) begin
            r_zout <= r_zero[QBITS];
            for (int a = 0; a < 3; a++) begin
                if (r_ovf[QBITS][a] || r_q[QBITS][a][QBITS-1]) begin
                    r_val[a] <= r_neg[QBITS][a] ? {1'b1, {(WORD_W-1){1'b0}}}
                                                : {1'b0, {(WORD_W-1){1'b1}}};
                end else if (r_neg[QBITS][a]) begin
                    r_val[a] <= -t_word'(r_q[QBITS][a]);
                end else begin
                    r_val[a] <= t_word'(r_q[QBITS][a]);
                end
            end
        end
    end

    assign o_val  = r_val;
    assign o_zero = r_zout;

endmodule

>>> rtl/afc_reduce.sv
`timescale 1ns / 1ps
// ============================================================================
// afc_reduce
// Per-axis minimum and maximum over the corners, then the overlap test
// against the view box and the output register.
// ============================================================================
module afc_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic [1:0]                i_en,
    input  afc_pkg::t_corn_val        i_val,
    input  logic [afc_pkg::NUM_CORN-1:0] i_zero,
    output logic                      o_inside,
    output logic                      o_degen,
    output afc_pkg::t_vec3            o_vmin,
    output afc_pkg::t_vec3            o_vmax
);
    import afc_pkg::*;

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    t_word r_mn [3];
    t_word r_mx [3];
    logic  r_dg;
    t_word r_omn [3];
    t_word r_omx [3];
    logic  r_oin;
    logic  r_odg;

    // A compare tree over the eight corners. Values of corners with w equal to
    // zero do not matter here, because such an item is replaced by zeros in the
    // next stage.
    always_ff @(posedge i_clk) begin
        t_word mn4 [4];
        t_word mx4 [4];
        t_word mn2 [2];
        t_word mx2 [2];
        if (i_en[0]) begin
            r_dg <= |i_zero;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 4; k++) begin
                    mn4[k] = (i_val[2*k][a] < i_val[2*k+1][a]) ? i_val[2*k][a]
                                                               : i_val[2*k+1][a];
                    mx4[k] = (i_val[2*k][a] > i_val[2*k+1][a]) ? i_val[2*k][a]
                                                               : i_val[2*k+1][a];
                end
                for (int k = 0; k < 2; k++) begin
                    mn2[k] = (mn4[2*k] < mn4[2*k+1]) ? mn4[2*k] : mn4[2*k+1];
                    mx2[k] = (mx4[2*k] > mx4[2*k+1]) ? mx4[2*k] : mx4[2*k+1];
                end
                r_mn[a] <= (mn2[0] < mn2[1]) ? mn2[0] : mn2[1];
                r_mx[a] <= (mx2[0] > mx2[1]) ? mx2[0] : mx2[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_odg <= r_dg;
            if (r_dg) begin
                r_oin <= 1'b1;
                for (int a = 0; a < 3; a++) begin
                    r_omn[a] <= '0;
                    r_omx[a] <= '0;
                end
            end else begin
                r_oin <= (r_mn[0] <= ONE) && (r_mx[0] >= -ONE) &&
                         (r_mn[1] <= ONE) && (r_mx[1] >= -ONE) &&
                         (r_mn[2] <= ONE) && (r_mx[2] >= t_word'(0));
                for (int a = 0; a < 3; a++) begin
                    r_omn[a] <= r_mn[a];
                    r_omx[a] <= r_mx[a];
                end
            end
        end
    end

    assign o_inside = r_oin;
    assign o_degen  = r_odg;
    assign o_vmin   = r_omn;
    assign o_vmax   = r_omx;

endmodule
